>>> hw/rtl/ssd_pkg.sv
`timescale 1ns / 1ps
package ssd_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CHECKSUM    = 3'd1,
    ST_TIMEOUT     = 3'd2,
    ST_ID_MISMATCH = 3'd3,
    ST_SERVO_ERR   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HUNT    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_t;

  localparam logic [7:0]  PREAMBLE    = 8'hFF;
  localparam logic [7:0]  MAX_ID      = 8'hFD;
  localparam logic [7:0]  MAX_ERR     = 8'h7F;
  localparam logic [7:0]  MIN_LEN     = 8'd2;
  localparam logic [15:0] TIMEOUT_RST = 16'd20;
  localparam int          HDR_LEN     = 6;
  localparam int          FRAME_OVH   = 4;
  localparam int          IDX_W       = 6;
  localparam int          CNT_W       = 7;
  localparam int          Q_DEPTH     = 2;

  typedef struct packed {
    status_t          status;
    logic [7:0]       servo_id;
    logic [6:0]       error_flags;
    logic [IDX_W-1:0] n_params;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } pwr_t;

endpackage

>>> hw/rtl/ssd_front.sv
`timescale 1ns / 1ps
module ssd_front #(
  parameter int RX_MAX_LEN = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_byte,
  input  logic [7:0]       in_exp_id,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             q_full,
  input  logic             run_done,
  output logic             job_push,
  output ssd_pkg::job_t    job,
  output ssd_pkg::pwr_t    pwr
);

  localparam int WIN = ssd_pkg::HDR_LEN - 1;
  localparam int CW  = ssd_pkg::CNT_W;

  ssd_pkg::phase_t   phase_r, phase_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [7:0]        win_r [WIN];
  logic [7:0]        win_nxt [WIN];
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [15:0]       elapsed_r, elapsed_nxt;
  logic [15:0]       tmo_r;
  logic [7:0]        target_r, target_nxt;
  logic              busy_r, busy_nxt;

  logic              accept;
  logic              is_start, is_byte, is_tick;
  logic [7:0]        w [ssd_pkg::HDR_LEN];
  logic [2:0]        idx;
  logic [7:0]        hlen;
  logic              hdr_ok;
  logic [CW-1:0]     total;
  logic              hunt_eval, hunt_done, hunt_go, coll_last, fin, tmo_hit;
  logic [7:0]        fin_sum;
  ssd_pkg::status_t  fin_status;

  assign in_ready = !q_full && !busy_r;
  assign accept   = in_valid && in_ready;
  assign is_start = accept && (in_op == ssd_pkg::OP_START);
  assign is_byte  = accept && (in_op == ssd_pkg::OP_BYTE);
  assign is_tick  = accept && (in_op == ssd_pkg::OP_TICK);

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      w[j] = win_r[j];
    end
    w[WIN] = in_byte;
  end

  // first FF FF pair in the full window, else keep only the newest byte
  always_comb begin
    idx = 3'(WIN);
    for (int i = WIN - 1; i >= 0; i--) begin
      if (w[i] == ssd_pkg::PREAMBLE && w[i+1] == ssd_pkg::PREAMBLE) begin
        idx = 3'(i);
      end
    end
  end

  assign hlen   = win_r[3];
  assign hdr_ok = (win_r[2] <= ssd_pkg::MAX_ID) && (hlen >= ssd_pkg::MIN_LEN) &&
                  (({1'b0, hlen} + 9'(ssd_pkg::FRAME_OVH)) <= 9'(RX_MAX_LEN)) &&
                  (win_r[4] <= ssd_pkg::MAX_ERR);
  assign total  = hlen[CW-1:0] + CW'(ssd_pkg::FRAME_OVH);

  assign hunt_eval = (phase_r == ssd_pkg::PH_HUNT) && is_byte && (cnt_r == 3'(WIN));
  assign hunt_done = hunt_eval && (idx == 3'd0) && hdr_ok && (hlen == ssd_pkg::MIN_LEN);
  assign hunt_go   = hunt_eval && (idx == 3'd0) && hdr_ok && (hlen != ssd_pkg::MIN_LEN);
  assign coll_last = (phase_r == ssd_pkg::PH_COLLECT) && is_byte &&
                     (pos_r == total - CW'(1));
  assign fin       = hunt_done || coll_last;
  assign tmo_hit   = (phase_r != ssd_pkg::PH_IDLE) && is_tick && (elapsed_r >= tmo_r);

  assign fin_sum = hunt_done ? (win_r[2] + win_r[3] + win_r[4]) : sum_r;

  always_comb begin
    if (~fin_sum != in_byte) begin
      fin_status = ssd_pkg::ST_CHECKSUM;
    end else if (win_r[2] != target_r) begin
      fin_status = ssd_pkg::ST_ID_MISMATCH;
    end else if (win_r[4] != 8'd0) begin
      fin_status = ssd_pkg::ST_SERVO_ERR;
    end else begin
      fin_status = ssd_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (is_start) begin
      phase_nxt = ssd_pkg::PH_HUNT;
    end else begin
      unique case (phase_r)
        ssd_pkg::PH_IDLE: begin
          phase_nxt = ssd_pkg::PH_IDLE;
        end
        ssd_pkg::PH_HUNT: begin
          if (tmo_hit || hunt_done) begin
            phase_nxt = ssd_pkg::PH_IDLE;
          end else if (hunt_go) begin
            phase_nxt = ssd_pkg::PH_COLLECT;
          end
        end
        ssd_pkg::PH_COLLECT: begin
          if (tmo_hit || coll_last) begin
            phase_nxt = ssd_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_nxt = ssd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    logic [2:0] sh;
    int         k;
    sh          = (idx != 3'd0) ? idx : 3'd1;
    k           = 0;
    win_nxt     = win_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    elapsed_nxt = elapsed_r;
    target_nxt  = target_r;
    job_push    = 1'b0;
    job         = '0;
    pwr         = '0;
    if (is_start) begin
      cnt_nxt     = 3'd0;
      elapsed_nxt = 16'd0;
      target_nxt  = in_exp_id;
    end else begin
      if (tmo_hit) begin
        job_push   = 1'b1;
        job.status = ssd_pkg::ST_TIMEOUT;
      end else if (is_tick && phase_r != ssd_pkg::PH_IDLE) begin
        elapsed_nxt = elapsed_r + 16'd1;
      end
      if (phase_r == ssd_pkg::PH_HUNT && is_byte) begin
        if (!hunt_eval) begin
          win_nxt[cnt_r] = in_byte;
          cnt_nxt        = cnt_r + 3'd1;
        end else if (idx != 3'd0 || !hdr_ok) begin
          for (int j = 0; j < WIN; j++) begin
            k = j + int'(sh);
            if (k <= WIN) begin
              win_nxt[j] = w[k];
            end
          end
          cnt_nxt = 3'(ssd_pkg::HDR_LEN) - sh;
        end else if (hlen != ssd_pkg::MIN_LEN) begin
          pos_nxt  = CW'(ssd_pkg::HDR_LEN);
          sum_nxt  = win_r[2] + win_r[3] + win_r[4] + in_byte;
          pwr.en   = 1'b1;
          pwr.data = in_byte;
        end
      end
      if (phase_r == ssd_pkg::PH_COLLECT && is_byte && !coll_last) begin
        pwr.en   = 1'b1;
        pwr.addr = ssd_pkg::IDX_W'(pos_r - CW'(WIN));
        pwr.data = in_byte;
        sum_nxt  = sum_r + in_byte;
        pos_nxt  = pos_r + CW'(1);
      end
      if (fin) begin
        job_push        = 1'b1;
        job.status      = fin_status;
        job.servo_id    = win_r[2];
        job.error_flags = win_r[4][6:0];
        job.n_params    = (fin_status == ssd_pkg::ST_OK) ?
                          ssd_pkg::IDX_W'(hlen - ssd_pkg::MIN_LEN) : '0;
      end
    end
  end

  // input held off from a parameter packet's push until its run is drained
  assign busy_nxt = (busy_r && !run_done) || (job_push && job.n_params != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ssd_pkg::PH_IDLE;
      cnt_r     <= 3'd0;
      elapsed_r <= 16'd0;
      tmo_r     <= ssd_pkg::TIMEOUT_RST;
      target_r  <= 8'd0;
      busy_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      elapsed_r <= elapsed_nxt;
      target_r  <= target_nxt;
      busy_r    <= busy_nxt;
      if (cfg_wr_en) begin
        tmo_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    pos_r <= pos_nxt;
    sum_r <= sum_nxt;
  end

endmodule

>>> hw/rtl/ssd_queue.sv
`timescale 1ns / 1ps
module ssd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ssd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output ssd_pkg::job_t pop_job
);

  localparam int PW = (ssd_pkg::Q_DEPTH > 1) ? $clog2(ssd_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(ssd_pkg::Q_DEPTH + 1);

  ssd_pkg::job_t  mem_r [ssd_pkg::Q_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == CW'(ssd_pkg::Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_job   = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(ssd_pkg::Q_DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(ssd_pkg::Q_DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

>>> hw/rtl/ssd_back.sv
`timescale 1ns / 1ps
module ssd_back #(
  parameter int RX_MAX_LEN = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ssd_pkg::pwr_t pwr,
  input  logic          job_valid,
  input  ssd_pkg::job_t job,
  output logic          job_pop,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [31:0]   out_data,
  output logic          out_user,
  output logic          out_last,
  output logic          run_done,
  output logic          run_busy
);

  localparam int PDEPTH = RX_MAX_LEN - ssd_pkg::HDR_LEN;
  localparam int AW     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int IW     = ssd_pkg::IDX_W;

  logic [7:0]           pmem [PDEPTH];
  logic [7:0]           rd_data_r;
  logic                 rd_en;
  logic [IW-1:0]        rd_idx;

  ssd_pkg::bk_state_t   state_r, state_nxt;
  ssd_pkg::job_t        job_r;
  logic [IW-1:0]        idx_r;
  logic                 out_free, last_p, load_stat, load_par;

  logic                 out_valid_r;
  ssd_pkg::status_t     status_r;
  logic [7:0]           id_r;
  logic [6:0]           err_r;
  logic [IW-1:0]        pidx_r;
  logic [7:0]           pbyte_r;
  logic                 pvalid_r;
  logic                 last_r;

  assign out_free = !out_valid_r || out_ready;
  assign last_p   = (idx_r == job_r.n_params - IW'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssd_pkg::BK_IDLE: begin
        if (job_valid && job.n_params != '0) begin
          state_nxt = ssd_pkg::BK_RUN;
        end
      end
      ssd_pkg::BK_RUN: begin
        if (out_free && last_p) begin
          state_nxt = ssd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = ssd_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    job_pop   = 1'b0;
    rd_en     = 1'b0;
    rd_idx    = '0;
    load_stat = 1'b0;
    load_par  = 1'b0;
    unique case (state_r)
      ssd_pkg::BK_IDLE: begin
        if (job_valid && job.n_params != '0) begin
          job_pop = 1'b1;
          rd_en   = 1'b1;
        end else if (job_valid && out_free) begin
          job_pop   = 1'b1;
          load_stat = 1'b1;
        end
      end
      ssd_pkg::BK_RUN: begin
        if (out_free) begin
          load_par = 1'b1;
          if (!last_p) begin
            rd_en  = 1'b1;
            rd_idx = idx_r + IW'(1);
          end
        end
      end
      default: begin
        job_pop = 1'b0;
      end
    endcase
  end

  assign run_done = load_par && last_p;
  assign run_busy = (state_r == ssd_pkg::BK_RUN);

  always_ff @(posedge clk) begin
    if (pwr.en) begin
      pmem[pwr.addr[AW-1:0]] <= pwr.data;
    end
    if (rd_en) begin
      rd_data_r <= pmem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssd_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_stat || load_par) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
      idx_r <= '0;
    end else if (load_par) begin
      idx_r <= idx_r + IW'(1);
    end
    if (load_stat) begin
      status_r <= job.status;
      id_r     <= job.servo_id;
      err_r    <= job.error_flags;
      pidx_r   <= '0;
      pbyte_r  <= 8'd0;
      pvalid_r <= 1'b0;
      last_r   <= 1'b1;
    end else if (load_par) begin
      status_r <= ssd_pkg::ST_OK;
      id_r     <= job_r.servo_id;
      err_r    <= 7'd0;
      pidx_r   <= idx_r;
      pbyte_r  <= rd_data_r;
      pvalid_r <= 1'b1;
      last_r   <= last_p;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {pbyte_r, pidx_r, err_r, id_r, status_r};
  assign out_user  = pvalid_r;
  assign out_last  = last_r;

endmodule

>>> hw/rtl/servo_status_packet_deframer.sv
`timescale 1ns / 1ps
// Status reply deframer. While in_tready is high, start, byte and tick words are taken
// at one per cycle while hunting for the FF FF preamble and while collecting a packet.
// A finished packet becomes a job in a two-entry queue; a status result is loaded
// into the output register at the same edge that takes its job from the queue, in
// the cycle after the word that ends the packet when the queue was empty and the
// output register free. A good packet with N parameter bytes gives a run of N words:
// the first byte is read from the parameter store into a register, then one word per
// cycle follows while out_tready stays high. in_tready is low from the word that ends
// such a packet until the last word of its run is loaded into the output register,
// and while the job queue is full. No clearing pass follows reset.
module servo_status_packet_deframer #(
  parameter int RX_MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte, expected_id
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status, servo_id, error_flags, param_index, param_byte
  output logic        out_tuser,  // param_valid
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic          job_push;
  ssd_pkg::job_t push_job;
  ssd_pkg::pwr_t pwr;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  ssd_pkg::job_t q_job;
  logic          run_done;
  logic          run_busy;

  ssd_front #(
    .RX_MAX_LEN(RX_MAX_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_byte    (in_tdata[7:0]),
    .in_exp_id  (in_tdata[15:8]),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full     (q_full),
    .run_done   (run_done),
    .job_push   (job_push),
    .job        (push_job),
    .pwr        (pwr)
  );

  ssd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_job  (q_job)
  );

  ssd_back #(
    .RX_MAX_LEN(RX_MAX_LEN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pwr      (pwr),
    .job_valid(q_valid),
    .job      (q_job),
    .job_pop  (q_pop),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .out_data (out_tdata),
    .out_user (out_tuser),
    .out_last (out_tlast),
    .run_done (run_done),
    .run_busy (run_busy)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && q_full))
    else $error("job pushed into full queue");

  a_store_quiet_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    !(pwr.en && run_busy))
    else $error("parameter store written during a run");

  a_status_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && out_tdata[31:18] == 14'd0))
    else $error("status word with parameter content");

  a_timeout_word_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] == ssd_pkg::ST_TIMEOUT) |-> (out_tdata[17:3] == 15'd0))
    else $error("timeout word carries packet fields");

endmodule
